>>> design/b64sc_pkg.sv
// shared types, constants and alphabet functions for the base64 stream codec
`default_nettype none

package b64sc_pkg;

  localparam int unsigned RES_MAX   = 6;
  localparam int unsigned CNT_W     = $clog2(RES_MAX + 1);
  localparam int unsigned GROUP_W   = 24;
  localparam int unsigned POS_W     = 2;
  localparam int unsigned PAD_W     = 2;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
  localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
  localparam logic [POS_W-1:0] POS_THIRD  = 2'd2;
  localparam logic [POS_W-1:0] POS_FOURTH = 2'd3;

  localparam logic [PAD_W-1:0] PAD_SAT = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  typedef logic [RES_MAX-1:0][7:0] res_vec_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [7:0] c;
    begin
      if (s < 6'd26) begin
        c = 8'h41 + {2'b00, s};
      end else if (s < 6'd52) begin
        c = 8'h61 + {2'b00, s - 6'd26};
      end else if (s < 6'd62) begin
        c = 8'h30 + {2'b00, s - 6'd52};
      end else if (s == 6'd62) begin
        c = PLUS_CHAR;
      end else begin
        c = SLASH_CHAR;
      end
      return c;
    end
  endfunction

  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
        t = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        t = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
        t = c - 8'h30 + 8'd52;
      end else if (c == PLUS_CHAR) begin
        t = 8'd62;
      end else if (c == SLASH_CHAR) begin
        t = 8'd63;
      end
      return t[5:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> design/base64_stream_codec_unit.sv
// base64 stream codec top level: encode or decode one word per accepted item
`default_nettype none

// channel  | ports                          | payload
// ---------+--------------------------------+----------------------------
// input    | in_valid in_ready in_data      | in_byte, in_last
// output   | out_valid out_ready out_data   | out_byte, out_last
// config   | cfg_we cfg_wdata               | direction (0 enc, 1 dec)
//
// an item is taken when in_valid and in_ready are both high; its 0 to 6 result
// words queue in a result buffer and leave through the output register at one
// word per cycle while out_ready does not stall a waiting word. an item with no
// results does not hold the input; otherwise the next item is taken in the cycle
// the last word of the previous one moves to the output register.
// rst_n is synchronous; it clears direction, group and held state, buffer.

module base64_stream_codec_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire b64sc_pkg::in_word_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output b64sc_pkg::out_word_t out_data,
  input  wire                 cfg_we,
  input  wire                 cfg_wdata
);

  logic                              dir_r;
  logic [b64sc_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [b64sc_pkg::GROUP_W-1:0]     acc_r, acc_nxt;
  logic [b64sc_pkg::GROUP_W-1:0]     held_r, held_nxt;
  logic [b64sc_pkg::PAD_W-1:0]       held_pad_r, held_pad_nxt;
  logic                              held_valid_r, held_valid_nxt;
  logic [b64sc_pkg::PAD_W-1:0]       pad_r, pad_nxt;

  b64sc_pkg::res_vec_t               buf_r, buf_nxt;
  logic [b64sc_pkg::CNT_W-1:0]       buf_cnt_r, buf_cnt_nxt;
  logic                              buf_last_r;

  logic                              out_valid_r;
  b64sc_pkg::out_word_t              out_data_r;

  b64sc_pkg::res_vec_t               res;
  logic [b64sc_pkg::CNT_W-1:0]       res_cnt;

  logic                              accept, take;
  logic [7:0]                        b;
  logic                              eq;
  logic [5:0]                        sx;
  logic [b64sc_pkg::GROUP_W-1:0]     acc_new, sx_sh;
  logic [b64sc_pkg::PAD_W-1:0]       pad_new;
  logic                              rel_full, rel_trim, hold_new;
  logic [b64sc_pkg::CNT_W-1:0]       held_cnt, grp_cnt;

  assign take     = (buf_cnt_r != '0) && (!out_valid_r || out_ready);
  assign in_ready = (buf_cnt_r == '0) ||
                    ((buf_cnt_r == b64sc_pkg::CNT_W'(1)) && take);
  assign accept   = in_valid && in_ready;
  assign b        = in_data.in_byte;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // decode datapath
  always_comb begin
    eq = (b == b64sc_pkg::PAD_CHAR);
    sx = b64sc_pkg::char_to_sextet(b);
    case (pos_r)
      b64sc_pkg::POS_FIRST:  sx_sh = {sx, 18'd0};
      b64sc_pkg::POS_SECOND: sx_sh = {6'd0, sx, 12'd0};
      b64sc_pkg::POS_THIRD:  sx_sh = {12'd0, sx, 6'd0};
      default:               sx_sh = {18'd0, sx};
    endcase
    acc_new = acc_r | sx_sh;
    if (!eq) begin
      pad_new = '0;
    end else if (pad_r >= b64sc_pkg::PAD_SAT) begin
      pad_new = b64sc_pkg::PAD_SAT;
    end else begin
      pad_new = pad_r + b64sc_pkg::PAD_W'(1);
    end
    rel_full = held_valid_r && (!eq || (pos_r == b64sc_pkg::POS_FOURTH));
    rel_trim = held_valid_r && eq && (pos_r != b64sc_pkg::POS_FOURTH) && in_data.in_last;
    hold_new = (pos_r == b64sc_pkg::POS_FOURTH) && !in_data.in_last && (pad_new != '0);
    if (rel_full) begin
      held_cnt = b64sc_pkg::CNT_W'(3);
    end else if (rel_trim) begin
      held_cnt = b64sc_pkg::CNT_W'(3) - b64sc_pkg::CNT_W'(held_pad_r);
    end else begin
      held_cnt = '0;
    end
    if (pos_r != b64sc_pkg::POS_FOURTH || hold_new) begin
      grp_cnt = '0;
    end else if (in_data.in_last) begin
      grp_cnt = b64sc_pkg::CNT_W'(3) - b64sc_pkg::CNT_W'(pad_new);
    end else begin
      grp_cnt = b64sc_pkg::CNT_W'(3);
    end
  end

  // next state and result words for the current item
  always_comb begin
    res            = '0;
    res_cnt        = '0;
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    held_nxt       = held_r;
    held_pad_nxt   = held_pad_r;
    held_valid_nxt = held_valid_r;
    pad_nxt        = pad_r;
    if (dir_r == b64sc_pkg::DIR_DECODE) begin
      if (held_cnt != '0) begin
        res[0] = held_r[23:16];
        res[1] = held_r[15:8];
        res[2] = held_r[7:0];
        res[3] = acc_new[23:16];
        res[4] = acc_new[15:8];
        res[5] = acc_new[7:0];
      end else begin
        res[0] = acc_new[23:16];
        res[1] = acc_new[15:8];
        res[2] = acc_new[7:0];
      end
      res_cnt = held_cnt + grp_cnt;
      if (hold_new) begin
        held_nxt       = acc_new;
        held_pad_nxt   = pad_new;
        held_valid_nxt = 1'b1;
      end else if (rel_full) begin
        held_valid_nxt = 1'b0;
      end
      if (pos_r == b64sc_pkg::POS_FOURTH) begin
        acc_nxt = '0;
        pad_nxt = '0;
        pos_nxt = b64sc_pkg::POS_FIRST;
      end else begin
        acc_nxt = acc_new;
        pad_nxt = pad_new;
        pos_nxt = pos_r + b64sc_pkg::POS_W'(1);
      end
    end else begin
      case (pos_r)
        b64sc_pkg::POS_FIRST: begin
          acc_nxt = {b, 16'd0};
          res[0]  = b64sc_pkg::sextet_to_char(b[7:2]);
          res[1]  = b64sc_pkg::sextet_to_char({b[1:0], 4'd0});
          res[2]  = b64sc_pkg::PAD_CHAR;
          res[3]  = b64sc_pkg::PAD_CHAR;
          res_cnt = in_data.in_last ? b64sc_pkg::CNT_W'(4) : b64sc_pkg::CNT_W'(1);
          pos_nxt = b64sc_pkg::POS_SECOND;
        end
        b64sc_pkg::POS_SECOND: begin
          acc_nxt = {acc_r[23:16], b, 8'd0};
          res[0]  = b64sc_pkg::sextet_to_char({acc_r[17:16], b[7:4]});
          res[1]  = b64sc_pkg::sextet_to_char({b[3:0], 2'd0});
          res[2]  = b64sc_pkg::PAD_CHAR;
          res_cnt = in_data.in_last ? b64sc_pkg::CNT_W'(3) : b64sc_pkg::CNT_W'(1);
          pos_nxt = b64sc_pkg::POS_THIRD;
        end
        default: begin
          acc_nxt = '0;
          res[0]  = b64sc_pkg::sextet_to_char({acc_r[11:8], b[7:6]});
          res[1]  = b64sc_pkg::sextet_to_char(b[5:0]);
          res_cnt = b64sc_pkg::CNT_W'(2);
          pos_nxt = b64sc_pkg::POS_FIRST;
        end
      endcase
    end
    if (in_data.in_last) begin
      pos_nxt        = '0;
      acc_nxt        = '0;
      held_nxt       = '0;
      held_pad_nxt   = '0;
      held_valid_nxt = 1'b0;
      pad_nxt        = '0;
    end
  end

  // group and held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r        <= b64sc_pkg::DIR_ENCODE;
      pos_r        <= '0;
      acc_r        <= '0;
      held_r       <= '0;
      held_pad_r   <= '0;
      held_valid_r <= 1'b0;
      pad_r        <= '0;
    end else if (cfg_we) begin
      dir_r        <= cfg_wdata;
      pos_r        <= '0;
      acc_r        <= '0;
      held_r       <= '0;
      held_pad_r   <= '0;
      held_valid_r <= 1'b0;
      pad_r        <= '0;
    end else if (accept) begin
      pos_r        <= pos_nxt;
      acc_r        <= acc_nxt;
      held_r       <= held_nxt;
      held_pad_r   <= held_pad_nxt;
      held_valid_r <= held_valid_nxt;
      pad_r        <= pad_nxt;
    end
  end

  // result buffer, slot 0 leaves first
  always_comb begin
    buf_nxt     = buf_r;
    buf_cnt_nxt = buf_cnt_r;
    if (accept) begin
      buf_nxt     = res;
      buf_cnt_nxt = res_cnt;
    end else if (take) begin
      buf_nxt     = {8'h00, buf_r[b64sc_pkg::RES_MAX-1:1]};
      buf_cnt_nxt = buf_cnt_r - b64sc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= '0;
    end else begin
      buf_cnt_r <= buf_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (accept) begin
      buf_last_r <= in_data.in_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.out_byte <= buf_r[0];
      out_data_r.out_last <= buf_last_r && (buf_cnt_r == b64sc_pkg::CNT_W'(1));
    end
  end

  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt_r <= b64sc_pkg::CNT_W'(b64sc_pkg::RES_MAX))
    else $error("result buffer count out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_cnt_r > b64sc_pkg::CNT_W'(1)) |-> !in_ready)
    else $error("item taken while result buffer still busy");

  a_held_decode: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> (dir_r == b64sc_pkg::DIR_DECODE) && (held_pad_r != '0))
    else $error("held group outside decode or without pad count");

  a_enc_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (dir_r == b64sc_pkg::DIR_ENCODE) |-> (pos_r != b64sc_pkg::POS_FOURTH))
    else $error("encode group position out of range");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("word moved from buffer but output not valid");

endmodule

`default_nettype wire
